### rtl/rbm_pkg.sv
// Shared types and constants for the ROM bank mapper.
// Holds default geometry, opcodes, register indexes, reset values, stream widths
// and the slot-table rebuild request. No dependencies; used by every file but rbm_ram.
package rbm_pkg;

  // Default geometry
  localparam int SLOT_COUNT_DEF     = 8;
  localparam int MAX_BANKS_DEF      = 32;
  localparam int OFFSET_BITS_DEF    = 13;
  localparam int BANK_BITS_DEF      = 8;

  // Fixed field widths
  localparam int OPCODE_W   = 2;
  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 8;
  localparam int ROM_IDX_W  = 18;
  localparam int IN_TDATA_W = 48;  // 42 payload bits padded to whole bytes
  localparam int OUT_TDATA_W = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Register reset values
  localparam logic [2:0] MAP_BEGIN_RST  = 3'd2;
  localparam logic [2:0] MAP_END_RST    = 3'd5;
  localparam logic [4:0] FIRST_BANK_RST = 5'd0;
  localparam logic [5:0] NUM_BANKS_RST  = 6'd32;
  localparam logic       FIXED_MAP_RST  = 1'b0;
  localparam logic [7:0] BLANK_FILL_RST = 8'hFF;

  typedef enum logic [OPCODE_W-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LOAD  = 2'd2,
    OP_RSVD  = 2'd3
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_BEGIN  = 3'd0,
    CFG_MAP_END    = 3'd1,
    CFG_FIRST_BANK = 3'd2,
    CFG_NUM_BANKS  = 3'd3,
    CFG_FIXED_MAP  = 3'd4,
    CFG_BLANK_FILL = 3'd5
  } cfg_idx_e;

  // Request to rebuild the slot table from the layout registers
  typedef struct packed {
    logic       init;
    logic [2:0] map_begin;
    logic [2:0] map_end;
    logic [4:0] first_bank;
  } slot_init_t;

endpackage

### rtl/rom_bank_mapper_core.sv
// Top level of the ROM bank mapper: stream ports, registers, pipeline.
// Depends on rbm_pkg, rbm_ram and rbm_slot_map.
//
// Channel   Direction  Content
// s_axis    in         tuser: opcode; tdata: bus_address, bus_data, rom_index
// m_axis    out        tdata: read_data
// cfg       in         write enable, register index, write data
//
// One item per cycle while results are taken; a result passes stage b, which waits on
// the registered ROM read port, and then the output register before it is offered.
// Output register plus one stage in flight: input stalls only when both are full
// and the result is not taken.
// Reset clears the pipeline and the registers and rebuilds the slot table;
// the ROM is not cleared and must be loaded before it is read.
module rom_bank_mapper_core #(
  parameter int SLOT_COUNT  = rbm_pkg::SLOT_COUNT_DEF,
  parameter int MAX_BANKS   = rbm_pkg::MAX_BANKS_DEF,
  parameter int OFFSET_BITS = rbm_pkg::OFFSET_BITS_DEF,
  parameter int BANK_BITS   = rbm_pkg::BANK_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [15:0] bus_address, [23:16] bus_data, [41:24] rom_index, [47:42] zero
  input  logic [rbm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [1:0] opcode
  input  logic [rbm_pkg::OPCODE_W-1:0]     s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [7:0] read_data
  output logic [rbm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [rbm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rbm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import rbm_pkg::*;

  localparam int BANK_AW  = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;
  localparam int BANK_W   = (BANK_BITS > BANK_AW) ? BANK_BITS : BANK_AW;
  localparam int SLOT_W   = $clog2(SLOT_COUNT);
  localparam int ROM_DEPTH = MAX_BANKS * (2 ** OFFSET_BITS);
  localparam int ROM_AW   = $clog2(ROM_DEPTH);
  localparam int IDX_CW   = ((ROM_AW > ROM_IDX_W) ? ROM_AW : ROM_IDX_W) + 1;
  localparam int HI_W     = (ADDR_W > OFFSET_BITS) ? (ADDR_W - OFFSET_BITS) : 1;
  localparam int REM_W    = HI_W + 5;
  localparam int CMP_W    = 10;

  // Slot number modulo the slot count, one conditional subtract per bit
  function automatic logic [SLOT_W-1:0] slot_of(logic [HI_W-1:0] hi);
    logic [REM_W-1:0] rem;
    rem = REM_W'(hi);
    for (int k = HI_W - 1; k >= 0; k--) begin
      if (rem >= (REM_W'(SLOT_COUNT) << k)) begin
        rem = rem - (REM_W'(SLOT_COUNT) << k);
      end
    end
    return rem[SLOT_W-1:0];
  endfunction

  // Unpack the input item
  opcode_e                opcode;
  logic [ADDR_W-1:0]      bus_address;
  logic [DATA_W-1:0]      bus_data;
  logic [ROM_IDX_W-1:0]   rom_index;
  logic [ADDR_W:0]        addr_shift;
  logic [SLOT_W-1:0]      slot;
  logic [OFFSET_BITS-1:0] offset;

  assign opcode      = opcode_e'(s_axis_tuser);
  assign bus_address = s_axis_tdata[ADDR_W-1:0];
  assign bus_data    = s_axis_tdata[ADDR_W +: DATA_W];
  assign rom_index   = s_axis_tdata[ADDR_W+DATA_W +: ROM_IDX_W];
  assign addr_shift  = {1'b0, bus_address} >> OFFSET_BITS;
  assign slot        = slot_of(addr_shift[HI_W-1:0]);
  assign offset      = bus_address[OFFSET_BITS-1:0];

  // Configuration registers
  logic [2:0] map_begin_q, map_begin_d;
  logic [2:0] map_end_q, map_end_d;
  logic [4:0] first_bank_q, first_bank_d;
  logic [5:0] num_banks_q, num_banks_d;
  logic       fixed_map_q, fixed_map_d;
  logic [7:0] blank_fill_q, blank_fill_d;
  slot_init_t slot_init;

  always_comb begin
    map_begin_d    = map_begin_q;
    map_end_d      = map_end_q;
    first_bank_d   = first_bank_q;
    num_banks_d    = num_banks_q;
    fixed_map_d    = fixed_map_q;
    blank_fill_d   = blank_fill_q;
    slot_init.init = 1'b0;
    if (cfg_we_i) begin
      slot_init.init = 1'b1;
      case (cfg_idx_e'(cfg_index_i))
        CFG_MAP_BEGIN:  map_begin_d  = cfg_data_i[2:0];
        CFG_MAP_END:    map_end_d    = cfg_data_i[2:0];
        CFG_FIRST_BANK: first_bank_d = cfg_data_i[4:0];
        CFG_NUM_BANKS:  num_banks_d  = cfg_data_i[5:0];
        CFG_FIXED_MAP:  fixed_map_d  = cfg_data_i[0];
        CFG_BLANK_FILL: blank_fill_d = cfg_data_i;
        default:        slot_init.init = 1'b0;  // unknown index: no rebuild
      endcase
    end
    slot_init.map_begin  = map_begin_d;
    slot_init.map_end    = map_end_d;
    slot_init.first_bank = first_bank_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_begin_q  <= MAP_BEGIN_RST;
      map_end_q    <= MAP_END_RST;
      first_bank_q <= FIRST_BANK_RST;
      num_banks_q  <= NUM_BANKS_RST;
      fixed_map_q  <= FIXED_MAP_RST;
      blank_fill_q <= BLANK_FILL_RST;
    end else begin
      map_begin_q  <= map_begin_d;
      map_end_q    <= map_end_d;
      first_bank_q <= first_bank_d;
      num_banks_q  <= num_banks_d;
      fixed_map_q  <= fixed_map_d;
      blank_fill_q <= blank_fill_d;
    end
  end

  // Pipeline handshake: stage b waits on ROM data, out register faces m_axis
  logic b_valid_q, b_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_adv, b_adv, accept;

  assign out_adv       = !out_valid_q || m_axis_tready;
  assign b_adv         = b_valid_q && out_adv;
  assign s_axis_tready = !b_valid_q || out_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Slot table
  logic              slot_mapped;
  logic [BANK_W-1:0] slot_bank;
  logic              slot_wr;

  assign slot_wr = accept && (opcode == OP_WRITE) && !fixed_map_q;

  rbm_slot_map #(
    .SLOT_COUNT(SLOT_COUNT),
    .MAX_BANKS (MAX_BANKS),
    .BANK_W    (BANK_W)
  ) u_slot_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .init_i     (slot_init),
    .wr_en_i    (slot_wr),
    .wr_slot_i  (slot),
    .wr_bank_i  (BANK_W'(bus_data[BANK_BITS-1:0])),
    .rd_slot_i  (slot),
    .rd_mapped_o(slot_mapped),
    .rd_bank_o  (slot_bank)
  );

  // Blank when unmapped or the bank is past the real bank count or MAX_BANKS
  logic blank;
  assign blank = !slot_mapped
              || (CMP_W'(slot_bank) >= CMP_W'(num_banks_q))
              || (CMP_W'(slot_bank) >= CMP_W'(MAX_BANKS));

  // ROM memory: reads use bank and offset, loads use the byte index
  logic              load_ok;
  logic              rom_re, rom_we;
  logic [ROM_AW-1:0] rom_addr;
  logic [7:0]        rom_rdata;

  assign load_ok  = IDX_CW'(rom_index) < IDX_CW'(ROM_DEPTH);
  assign rom_re   = accept && (opcode == OP_READ);
  assign rom_we   = accept && (opcode == OP_LOAD) && load_ok;
  assign rom_addr = (opcode == OP_READ) ? ROM_AW'({slot_bank[BANK_AW-1:0], offset})
                                        : ROM_AW'(rom_index);

  rbm_ram #(
    .WIDTH(8),
    .DEPTH(ROM_DEPTH)
  ) u_rom (
    .clk_i  (clk_i),
    .we_i   (rom_we),
    .re_i   (rom_re),
    .addr_i (rom_addr),
    .wdata_i(bus_data),
    .rdata_o(rom_rdata)
  );

  // Stage b payload
  logic       b_read_q;
  logic       b_blank_q;
  logic [7:0] b_fill_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_read_q  <= (opcode == OP_READ);
      b_blank_q <= blank;
      b_fill_q  <= blank_fill_q;
    end
  end

  // Output register payload: ROM byte, fill byte, or zero for non-reads
  logic [7:0] out_data_q, out_data_d;

  always_comb begin
    if (!b_read_q) begin
      out_data_d = '0;
    end else if (b_blank_q) begin
      out_data_d = b_fill_q;
    end else begin
      out_data_d = rom_rdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      out_data_q <= out_data_d;
    end
  end

  // Advance valid flags
  assign b_valid_d   = accept || (b_valid_q && !out_adv);
  assign out_valid_d = b_adv || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      b_valid_q   <= b_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### rtl/rbm_ram.sv
// Generic single-port RAM with registered read data.
// No reset on the array; contents are undefined until written.
// Depends on nothing.
module rbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read; read data holds when not read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/rbm_slot_map.sv
// Per-slot bank table: bank number and mapped bit for each slot.
// Rebuilt from the layout registers at reset and on every register write.
// Depends on rbm_pkg.
module rbm_slot_map #(
  parameter int SLOT_COUNT = rbm_pkg::SLOT_COUNT_DEF,
  parameter int MAX_BANKS  = rbm_pkg::MAX_BANKS_DEF,
  parameter int BANK_W     = rbm_pkg::BANK_BITS_DEF,
  localparam int SLOT_W = $clog2(SLOT_COUNT)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rbm_pkg::slot_init_t init_i,
  input  logic                wr_en_i,
  input  logic [SLOT_W-1:0]   wr_slot_i,
  input  logic [BANK_W-1:0]   wr_bank_i,
  input  logic [SLOT_W-1:0]   rd_slot_i,
  output logic                rd_mapped_o,
  output logic [BANK_W-1:0]   rd_bank_o
);
  import rbm_pkg::*;

  // {mapped, bank} for one slot after a table rebuild
  function automatic logic [BANK_W:0] init_entry(int unsigned idx, logic [2:0] first,
                                                 logic [2:0] last, logic [4:0] entry);
    logic [9:0] nxt;
    logic       in_rng;
    nxt    = 10'(entry) + 10'(idx) - 10'(first);
    in_rng = (idx >= 32'(first)) && (idx <= 32'(last));
    return {in_rng && (nxt < 10'(MAX_BANKS)), nxt[BANK_W-1:0]};
  endfunction

  logic [SLOT_COUNT-1:0] mapped_q;
  logic [BANK_W-1:0]     bank_q [SLOT_COUNT];

  for (genvar s = 0; s < SLOT_COUNT; s++) begin : g_slot
    logic [BANK_W:0] rst_val;
    logic [BANK_W:0] init_val;
    assign rst_val  = init_entry(s, MAP_BEGIN_RST, MAP_END_RST, FIRST_BANK_RST);
    assign init_val = init_entry(s, init_i.map_begin, init_i.map_end, init_i.first_bank);

    // Rebuild wins over a bank switch write
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mapped_q[s] <= rst_val[BANK_W];
        bank_q[s]   <= rst_val[BANK_W-1:0];
      end else if (init_i.init) begin
        mapped_q[s] <= init_val[BANK_W];
        bank_q[s]   <= init_val[BANK_W-1:0];
      end else if (wr_en_i && (wr_slot_i == SLOT_W'(s))) begin
        mapped_q[s] <= 1'b1;
        bank_q[s]   <= wr_bank_i;
      end
    end
  end

  // Look up the addressed slot
  assign rd_mapped_o = mapped_q[rd_slot_i];
  assign rd_bank_o   = bank_q[rd_slot_i];

endmodule

### rtl/rbm_chk.sv
// Port-level checker for the ROM bank mapper, bound to the top level.
// Tracks items in flight between the two stream sides.
// Depends on rbm_pkg.
module rbm_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [rbm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  logic       in_acc, out_acc;
  logic [1:0] cnt_q, cnt_d;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign cnt_d   = cnt_q + {1'b0, in_acc} - {1'b0, out_acc};

  // Count items accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Never more items inside than the two stages hold
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("more items in flight than stages");

  // A result is offered only for an item that went in
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (cnt_q != 2'd0))
    else $error("result offered with no item in flight");

  // Input stalls only when both stages are full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (cnt_q == 2'd2))
    else $error("input stalled while a stage is free");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result dropped or changed");

endmodule

bind rom_bank_mapper_core rbm_chk u_rbm_chk (.*);
